>>> rtl/core/gfba_pkg.sv
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared widths, command and status codes, and the divider result type for
// the grouped free-block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

  localparam int OFFSET_W = 19;
  localparam int STATUS_W = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALL_FREE   = 3'd4;

  typedef struct packed {
    logic                done;
    logic                aligned;
    logic [OFFSET_W-1:0] quot;
  } div_res_t;

endpackage

>>> rtl/core/grouped_free_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_unit
// Grouped free-list block allocator: allocate and free commands against an
// in-core group stack, a per-block group store and an in-use bitmap.
// ----------------------------------------------------------------------------
// One command at a time. After reset a clearing pass writes the formatted
// chain into the group store, group zero into the stack and zeros into the
// bitmap; no command is taken meanwhile. An allocate does one stack read,
// then the update; an allocate that empties the stack goes on to reload it
// from the group store, one word a cycle. A free splits the offset into
// block number and remainder (BLOCK_BYTES is a power of two), does one
// bitmap read, then the update; a misaligned or out-of-range free answers
// straight after the split. A free onto a full stack goes on to save the
// stack into the old head. The result sits in an output register, so the
// next command is taken while it waits.
module grouped_free_block_allocator_unit #(
  parameter int BLOCK_COUNT = 1024,
  parameter int GROUP_SIZE  = 16,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic                          command,
  input  logic [gfba_pkg::OFFSET_W-1:0] block_offset,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [gfba_pkg::OFFSET_W-1:0] granted_offset,
  output logic [gfba_pkg::STATUS_W-1:0] status
);
  import gfba_pkg::*;

  localparam int W        = $clog2(BLOCK_COUNT) + 1;
  localparam int BIW      = $clog2(BLOCK_COUNT);
  localparam int CW       = $clog2(BLOCK_COUNT + 1);
  localparam int GIW      = $clog2(GROUP_SIZE);
  localparam int SCW      = $clog2(GROUP_SIZE + 1);
  localparam int GS_DEPTH = BLOCK_COUNT * GROUP_SIZE;
  localparam int GS_AW    = $clog2(GS_DEPTH);

  localparam logic [W-1:0]     NO_BLOCK = '1;
  localparam logic [W-1:0]     BC_W     = W'(BLOCK_COUNT);
  localparam logic [W-1:0]     G_W      = W'(GROUP_SIZE);
  localparam logic [GIW-1:0]   TOP_LAST = GIW'(GROUP_SIZE - 1);
  localparam logic [SCW-1:0]   SW_LAST  = SCW'(GROUP_SIZE);
  localparam logic [GS_AW-1:0] GS_LAST  = GS_AW'(GS_DEPTH - 1);
  localparam logic [GS_AW-1:0] G_A      = GS_AW'(GROUP_SIZE);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_AREAD = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_SAVE  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state, state_next;
  logic [W-1:0]        head_block, head_block_next;
  logic [CW-1:0]       free_count, free_count_next;
  logic [GIW-1:0]      top_idx, top_idx_next;
  logic [W-1:0]        got_blk, got_blk_next;
  logic [W-1:0]        bno, bno_next;
  logic [GS_AW-1:0]    base_addr, base_addr_next;
  logic                row_valid, row_valid_next;
  logic [SCW-1:0]      sweep_cnt, sweep_cnt_next;
  logic [BIW-1:0]      clr_blk, clr_blk_next;
  logic [GIW-1:0]      clr_j, clr_j_next;
  logic [GIW-1:0]      clr_phase, clr_phase_next;
  logic [GS_AW-1:0]    clr_addr, clr_addr_next;
  logic                res_valid_next;
  logic [OFFSET_W-1:0] granted_offset_next, pend_grant, pend_grant_next;
  logic [STATUS_W-1:0] status_next, pend_status, pend_status_next;

  logic                gs_we;
  logic [GS_AW-1:0]    gs_waddr, gs_raddr;
  logic [W-1:0]        gs_wdata, gs_rdata;
  logic                stk_we;
  logic [GIW-1:0]      stk_waddr, stk_raddr;
  logic [W-1:0]        stk_wdata, stk_rdata;
  logic                map_we;
  logic [BIW-1:0]      map_waddr, map_raddr;
  logic                map_wdata, map_rdata;

  logic [W-1:0]        gs_mem  [GS_DEPTH];
  logic [W-1:0]        stk_mem [GROUP_SIZE];
  logic                map_mem [BLOCK_COUNT];

  div_res_t            div_res;
  logic                div_start;

  logic                fin_valid;
  logic                fin_grant_en;
  logic [STATUS_W-1:0] fin_status;
  logic [W-1:0]        fin_got;
  logic [31:0]         fin_prod;
  logic [OFFSET_W-1:0] fin_grant;
  logic                out_free;

  logic [W-1:0]        clr_link, clr_member, clr_value;
  logic [W-1:0]        alloc_got;
  logic [GIW-1:0]      sweep_idx;

  gfba_div #(
    .DIVISOR(BLOCK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(block_offset),
    .res     (div_res)
  );

  always_ff @(posedge clk) begin
    if (gs_we) begin
      gs_mem[gs_waddr] <= gs_wdata;
    end
    gs_rdata <= gs_mem[gs_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata <= map_mem[map_raddr];
  end

  assign clr_link   = W'(clr_blk) + G_W;
  assign clr_member = W'(clr_blk) + W'(clr_j);
  always_comb begin
    if (clr_phase != '0) begin
      clr_value = NO_BLOCK;
    end else if (clr_j != '0) begin
      clr_value = clr_member;
    end else begin
      clr_value = (clr_link < BC_W) ? clr_link : NO_BLOCK;
    end
  end

  assign alloc_got = (top_idx == '0) ? head_block : stk_rdata;
  assign sweep_idx = GIW'(sweep_cnt - 1'b1);
  assign fin_prod  = 32'(fin_got) * 32'(BLOCK_BYTES);
  assign fin_grant = fin_grant_en ? fin_prod[OFFSET_W-1:0] : '0;
  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next          = state;
    head_block_next     = head_block;
    free_count_next     = free_count;
    top_idx_next        = top_idx;
    got_blk_next        = got_blk;
    bno_next            = bno;
    base_addr_next      = base_addr;
    row_valid_next      = row_valid;
    sweep_cnt_next      = sweep_cnt;
    clr_blk_next        = clr_blk;
    clr_j_next          = clr_j;
    clr_phase_next      = clr_phase;
    clr_addr_next       = clr_addr;
    res_valid_next      = res_valid;
    granted_offset_next = granted_offset;
    status_next         = status;
    pend_grant_next     = pend_grant;
    pend_status_next    = pend_status;

    gs_we     = 1'b0;
    gs_waddr  = '0;
    gs_wdata  = NO_BLOCK;
    gs_raddr  = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = NO_BLOCK;
    stk_raddr = top_idx;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = 1'b0;
    map_raddr = '0;
    div_start = 1'b0;

    fin_valid    = 1'b0;
    fin_grant_en = 1'b0;
    fin_status   = ST_OK;
    fin_got      = got_blk;

    unique case (state)
      S_CLEAR: begin
        gs_we    = 1'b1;
        gs_waddr = clr_addr;
        gs_wdata = clr_value;
        if (clr_blk == '0) begin
          stk_we    = 1'b1;
          stk_waddr = clr_j;
          stk_wdata = clr_value;
        end
        if (clr_j == '0) begin
          map_we    = 1'b1;
          map_waddr = clr_blk;
          map_wdata = 1'b0;
        end
        if (clr_j == TOP_LAST) begin
          clr_j_next     = '0;
          clr_blk_next   = clr_blk + 1'b1;
          clr_phase_next = (clr_phase == TOP_LAST) ? '0 : clr_phase + 1'b1;
        end else begin
          clr_j_next = clr_j + 1'b1;
        end
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == GS_LAST) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        stk_raddr = top_idx;
        if (cmd_valid) begin
          if (command == CMD_FREE) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else if (free_count == '0) begin
            fin_valid  = 1'b1;
            fin_status = ST_NO_FREE;
          end else begin
            state_next = S_AREAD;
          end
        end
      end

      S_AREAD: begin
        if (alloc_got >= BC_W) begin
          fin_valid  = 1'b1;
          fin_status = ST_NO_FREE;
        end else begin
          map_we          = 1'b1;
          map_waddr       = alloc_got[BIW-1:0];
          map_wdata       = 1'b1;
          free_count_next = free_count - 1'b1;
          got_blk_next    = alloc_got;
          if (top_idx == '0) begin
            head_block_next = stk_rdata;
            top_idx_next    = TOP_LAST;
            row_valid_next  = (stk_rdata < BC_W);
            base_addr_next  = (stk_rdata < BC_W) ? GS_AW'(stk_rdata) * G_A : '0;
            sweep_cnt_next  = '0;
            state_next      = S_LOAD;
          end else begin
            stk_we       = 1'b1;
            stk_waddr    = top_idx;
            stk_wdata    = NO_BLOCK;
            top_idx_next = top_idx - 1'b1;
            fin_valid    = 1'b1;
            fin_grant_en = 1'b1;
            fin_got      = alloc_got;
          end
        end
      end

      S_LOAD: begin
        gs_raddr = base_addr + GS_AW'(sweep_cnt);
        if (sweep_cnt != '0) begin
          stk_we    = 1'b1;
          stk_waddr = sweep_idx;
          stk_wdata = row_valid ? gs_rdata : NO_BLOCK;
        end
        if (sweep_cnt == SW_LAST) begin
          fin_valid    = 1'b1;
          fin_grant_en = 1'b1;
        end else begin
          sweep_cnt_next = sweep_cnt + 1'b1;
        end
      end

      S_DIV: begin
        map_raddr = div_res.quot[BIW-1:0];
        if (div_res.done) begin
          bno_next = div_res.quot[W-1:0];
          if (!div_res.aligned) begin
            fin_valid  = 1'b1;
            fin_status = ST_MISALIGNED;
          end else if (div_res.quot >= OFFSET_W'(BLOCK_COUNT)) begin
            fin_valid  = 1'b1;
            fin_status = ST_NOT_IN_USE;
          end else begin
            state_next = S_FCHK;
          end
        end
      end

      S_FCHK: begin
        if (!map_rdata) begin
          fin_valid  = 1'b1;
          fin_status = ST_NOT_IN_USE;
        end else if (free_count == CW'(BLOCK_COUNT)) begin
          fin_valid  = 1'b1;
          fin_status = ST_ALL_FREE;
        end else begin
          map_we          = 1'b1;
          map_waddr       = bno[BIW-1:0];
          map_wdata       = 1'b0;
          free_count_next = free_count + 1'b1;
          if (top_idx == TOP_LAST) begin
            top_idx_next    = '0;
            got_blk_next    = head_block;
            row_valid_next  = (head_block < BC_W);
            base_addr_next  = (head_block < BC_W) ? GS_AW'(head_block) * G_A : '0;
            head_block_next = bno;
            sweep_cnt_next  = '0;
            state_next      = S_SAVE;
          end else begin
            top_idx_next = top_idx + 1'b1;
            stk_we       = 1'b1;
            stk_waddr    = top_idx + 1'b1;
            stk_wdata    = bno;
            fin_valid    = 1'b1;
          end
        end
      end

      S_SAVE: begin
        stk_raddr = GIW'(sweep_cnt);
        if (sweep_cnt != '0) begin
          gs_we     = row_valid;
          gs_waddr  = base_addr + GS_AW'(sweep_idx);
          gs_wdata  = stk_rdata;
          stk_we    = 1'b1;
          stk_waddr = sweep_idx;
          stk_wdata = (sweep_idx == '0) ? got_blk : NO_BLOCK;
        end
        if (sweep_cnt == SW_LAST) begin
          fin_valid = 1'b1;
        end else begin
          sweep_cnt_next = sweep_cnt + 1'b1;
        end
      end

      S_DONE: begin
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // result register and the one-deep holding slot behind it
    if (state == S_DONE) begin
      if (out_free) begin
        res_valid_next      = 1'b1;
        granted_offset_next = pend_grant;
        status_next         = pend_status;
        state_next          = S_IDLE;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        res_valid_next      = 1'b1;
        granted_offset_next = fin_grant;
        status_next         = fin_status;
        state_next          = S_IDLE;
      end else begin
        pend_grant_next  = fin_grant;
        pend_status_next = fin_status;
        state_next       = S_DONE;
      end
    end else if (out_free) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      head_block <= '0;
      free_count <= CW'(BLOCK_COUNT);
      top_idx    <= TOP_LAST;
      sweep_cnt  <= '0;
      clr_blk    <= '0;
      clr_j      <= '0;
      clr_phase  <= '0;
      clr_addr   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head_block <= head_block_next;
      free_count <= free_count_next;
      top_idx    <= top_idx_next;
      sweep_cnt  <= sweep_cnt_next;
      clr_blk    <= clr_blk_next;
      clr_j      <= clr_j_next;
      clr_phase  <= clr_phase_next;
      clr_addr   <= clr_addr_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    got_blk        <= got_blk_next;
    bno            <= bno_next;
    base_addr      <= base_addr_next;
    row_valid      <= row_valid_next;
    granted_offset <= granted_offset_next;
    status         <= status_next;
    pend_grant     <= pend_grant_next;
    pend_status    <= pend_status_next;
  end

endmodule

>>> rtl/core/gfba_div.sv
// ----------------------------------------------------------------------------
// gfba_div
// Splits a byte offset into a block number and an in-block remainder for a
// power-of-two block size: a shift and a mask, registered once. Reports the
// block number and whether the remainder is zero in the cycle after start.
// ----------------------------------------------------------------------------
module gfba_div #(
  parameter int DIVISOR = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gfba_pkg::OFFSET_W-1:0] dividend,
  output gfba_pkg::div_res_t            res
);
  import gfba_pkg::*;

  localparam int                  SH       = $clog2(DIVISOR);
  localparam logic [OFFSET_W-1:0] LOW_MASK = OFFSET_W'(DIVISOR - 1);

  logic                done;
  logic                aligned;
  logic [OFFSET_W-1:0] quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= dividend >> SH;
      aligned <= ((dividend & LOW_MASK) == '0);
    end
  end

  assign res.done    = done;
  assign res.aligned = aligned;
  assign res.quot    = quo;

endmodule

>>> tb/sv/tb_grouped_free_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_grouped_free_block_allocator_unit
// Self-checking bench for the grouped free-block allocator. Commands are
// driven over a valid/stall channel with varying idle and stall rates and one
// long result hold-off. Every reply is predicted by an in-bench copy of the
// group stack, head block, free count, in-use bitmap and group store, and
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb_grouped_free_block_allocator_unit;
  import gfba_pkg::*;

  localparam int BLOCK_COUNT  = 1024;
  localparam int GROUP_SIZE   = 16;
  localparam int BLOCK_BYTES  = 512;
  localparam int BLK_W        = 11;
  localparam logic [BLK_W-1:0] NO_BLOCK = '1;
  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_LEN    = 90;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 900000;

  typedef enum logic [1:0] {
    PH_BUSY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE
  } idle_phase_t;

  typedef struct packed {
    logic                cmd;
    logic [OFFSET_W-1:0] off;
  } cmd_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  logic                command = CMD_ALLOC;
  logic [OFFSET_W-1:0] block_offset = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [OFFSET_W-1:0] granted_offset;
  logic [STATUS_W-1:0] status;

  // allocator shadow state
  logic [BLK_W-1:0] grp_stack [GROUP_SIZE];
  logic [BLK_W-1:0] head_blk;
  int               free_total;
  logic             in_use [BLOCK_COUNT];
  logic [BLK_W-1:0] group_mem [BLOCK_COUNT*GROUP_SIZE];

  cmd_item_t command_q [$];
  reply_t    reply_q [$];
  int        accepted_total = 0;
  int        fail_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        gen_done = 1'b0;
  int        cycle_count = 0;

  grouped_free_block_allocator_unit #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .GROUP_SIZE (GROUP_SIZE),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .command       (command),
    .block_offset  (block_offset),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .granted_offset(granted_offset),
    .status        (status)
  );

  function automatic bit roll(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int idle_pct(bit receiver);
    idle_phase_t ph;
    ph = idle_phase_t'((accepted_total / PHASE_LEN) % 4);
    case (ph)
      PH_SEND_IDLE:  return receiver ? 0 : 58;
      PH_RECV_STALL: return receiver ? 58 : 0;
      PH_BOTH_IDLE:  return 7;
      default:       return 0;
    endcase
  endfunction

  task automatic format_store();
    int groups;
    groups = BLOCK_COUNT / GROUP_SIZE;
    for (int i = 0; i < BLOCK_COUNT*GROUP_SIZE; i++) group_mem[i] = NO_BLOCK;
    for (int g = 0; g < groups; g++) begin
      group_mem[g*GROUP_SIZE*GROUP_SIZE] =
        (g + 1 < groups) ? BLK_W'((g + 1) * GROUP_SIZE) : NO_BLOCK;
      for (int j = 1; j < GROUP_SIZE; j++)
        group_mem[g*GROUP_SIZE*GROUP_SIZE + j] = BLK_W'(g*GROUP_SIZE + j);
    end
    for (int b = 0; b < BLOCK_COUNT; b++) in_use[b] = 1'b0;
    for (int j = 0; j < GROUP_SIZE; j++) grp_stack[j] = group_mem[j];
    head_blk   = '0;
    free_total = BLOCK_COUNT;
  endtask

  task automatic apply_command(input cmd_item_t it, output reply_t rep);
    int          top;
    int          bno;
    logic [BLK_W-1:0] got;
    int unsigned prod;
    rep.offset = '0;
    rep.status = ST_OK;
    if (it.cmd == CMD_ALLOC) begin
      if (free_total == 0) begin
        rep.status = ST_NO_FREE;
      end else begin
        top = (free_total - 1) % GROUP_SIZE;
        got = (top == 0) ? head_blk : grp_stack[top];
        if (got >= BLOCK_COUNT) begin
          rep.status = ST_NO_FREE;
        end else begin
          if (top == 0) begin
            head_blk = grp_stack[0];
            for (int j = 0; j < GROUP_SIZE; j++)
              grp_stack[j] = (head_blk < BLOCK_COUNT) ?
                             group_mem[head_blk*GROUP_SIZE + j] : NO_BLOCK;
          end else begin
            grp_stack[top] = NO_BLOCK;
          end
          free_total--;
          in_use[got] = 1'b1;
          prod = got * BLOCK_BYTES;
          rep.offset = prod[OFFSET_W-1:0];
        end
      end
    end else if (it.off % BLOCK_BYTES != 0) begin
      rep.status = ST_MISALIGNED;
    end else begin
      bno = it.off / BLOCK_BYTES;
      if (bno >= BLOCK_COUNT || !in_use[bno]) begin
        rep.status = ST_NOT_IN_USE;
      end else if (free_total >= BLOCK_COUNT) begin
        rep.status = ST_ALL_FREE;
      end else begin
        top = (free_total == 0) ? GROUP_SIZE - 1 : (free_total - 1) % GROUP_SIZE;
        if (top == GROUP_SIZE - 1) begin
          if (head_blk < BLOCK_COUNT)
            for (int j = 0; j < GROUP_SIZE; j++)
              group_mem[head_blk*GROUP_SIZE + j] = grp_stack[j];
          grp_stack[0] = head_blk;
          for (int j = 1; j < GROUP_SIZE; j++) grp_stack[j] = NO_BLOCK;
          head_blk = BLK_W'(bno);
        end else begin
          grp_stack[top + 1] = BLK_W'(bno);
        end
        free_total++;
        in_use[bno] = 1'b0;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    cmd_item_t it;
    reply_t    rep;
    bit        taken;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      taken = cmd_valid && !cmd_stall;
      if (taken) begin
        it.cmd = command;
        it.off = block_offset;
        apply_command(it, rep);
        reply_q.push_back(rep);
        accepted_total++;
      end
      if (!cmd_valid || taken) begin
        if (command_q.size() != 0 && !roll(idle_pct(1'b0))) begin
          it = command_q.pop_front();
          command      <= it.cmd;
          block_offset <= it.off;
          cmd_valid    <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // long result hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst && !hold_done && accepted_total >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected transfer: offset %h status %0d",
                   $time, granted_offset, status);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (granted_offset !== want.offset) begin
            $display("%0t: granted_offset expected %h actual %h",
                     $time, want.offset, granted_offset);
            fail_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, status);
            fail_count++;
          end
        end
      end
      res_stall <= (hold_left != 0) || roll(idle_pct(1'b1));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    cmd_item_t it;
    bit        descending;
    int        target;
    int        b;
    format_store();

    it = '{cmd: CMD_ALLOC, off: '1};
    command_q.push_back(it);
    it = '{cmd: CMD_FREE, off: 19'd1};
    command_q.push_back(it);
    it = '{cmd: CMD_FREE, off: '1};
    command_q.push_back(it);
    it = '{cmd: CMD_FREE, off: OFFSET_W'((BLOCK_COUNT - 1) * BLOCK_BYTES)};
    command_q.push_back(it);
    it = '{cmd: CMD_FREE, off: '0};
    command_q.push_back(it);
    it = '{cmd: CMD_FREE, off: OFFSET_W'((GROUP_SIZE - 1) * BLOCK_BYTES)};
    command_q.push_back(it);
    command_q.push_back(it);
    // walk through the whole first group and the head
    for (int i = 0; i < GROUP_SIZE; i++) begin
      it = '{cmd: CMD_ALLOC, off: OFFSET_W'($urandom())};
      command_q.push_back(it);
    end
    // block 0 back onto a full stack, then take the head again
    it = '{cmd: CMD_FREE, off: '0};
    command_q.push_back(it);
    it = '{cmd: CMD_ALLOC, off: '0};
    command_q.push_back(it);

    descending = 1'b1;
    target     = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      while (command_q.size() >= 2) @(negedge clk);
      if (descending && free_total <= target) begin
        descending = 1'b0;
        target     = free_total + $urandom_range(70, 10);
      end else if (!descending && free_total >= target) begin
        descending = 1'b1;
        target     = $urandom_range(5, 0);
      end
      if (roll(6)) begin
        it.cmd = 1'($urandom_range(1, 0));
        it.off = OFFSET_W'($urandom());
      end else if (roll(descending ? 96 : 15)) begin
        it.cmd = CMD_ALLOC;
        it.off = OFFSET_W'($urandom());
      end else begin
        b = $urandom_range(BLOCK_COUNT - 1, 0);
        for (int t = 0; t < 300 && !in_use[b]; t++)
          b = $urandom_range(BLOCK_COUNT - 1, 0);
        it.cmd = CMD_FREE;
        it.off = OFFSET_W'(b * BLOCK_BYTES);
      end
      command_q.push_back(it);
    end
    gen_done = 1'b1;
  end

  initial begin
    do @(negedge clk);
    while (!(gen_done && command_q.size() == 0 && !cmd_valid && reply_q.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && reply_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gfba_pkg.sv
rtl/core/gfba_div.sv
rtl/core/grouped_free_block_allocator_unit.sv
tb/sv/tb_grouped_free_block_allocator_unit.sv
